@@ rtl/bad_pkg.sv @@
// ----------------------------------------------------------------------------
// Box average downscaler package
// Shared word types, line store request and response types, register codes
// and the small divide helpers.
// ----------------------------------------------------------------------------
package bad_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned SUM_W      = 12;
	localparam int unsigned POS_W      = 12;
	localparam int unsigned WIDTH_W    = 12;
	localparam int unsigned HEIGHT_W   = 13;
	localparam int unsigned SCALE_W    = 2;
	localparam int unsigned LINE_DEPTH = 2048;
	localparam int unsigned IDX_W      = $clog2(LINE_DEPTH);
	localparam int unsigned MAX_HEIGHT = 4096;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [1:0] CFG_SCALE  = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam logic [SCALE_W-1:0] SCALE_1 = 2'd0;
	localparam logic [SCALE_W-1:0] SCALE_2 = 2'd1;
	localparam logic [SCALE_W-1:0] SCALE_3 = 2'd2;
	localparam logic [SCALE_W-1:0] SCALE_4 = 2'd3;

	// reciprocals: v/3 = (v*2731)>>13 for v < 4096, v/9 = (v*7282)>>16
	localparam logic [11:0] RECIP_3 = 12'd2731;
	localparam logic [12:0] RECIP_9 = 13'd7282;

	typedef struct packed {
		logic [PIX_W-1:0] in_blue;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_red;
		logic             frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_red;
		logic             row_end;
		logic             frame_end;
	} pix_out_t;

	typedef struct packed {
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] r;
	} sums_t;

	typedef struct packed {
		logic               wr;
		logic               outp;
		logic               ry0;
		logic [IDX_W-1:0]   idx;
		sums_t              sums;
		logic               row_end;
		logic               frame_end;
		logic [SCALE_W-1:0] scale;
	} acc_req_t;

	typedef struct packed {
		logic               outp;
		sums_t              sums;
		logic               row_end;
		logic               frame_end;
		logic [SCALE_W-1:0] scale;
	} acc_res_t;

	typedef struct packed {
		logic [POS_W-1:0] q;
		logic [1:0]       r;
	} qr_t;

	function automatic qr_t div_k(input logic [POS_W-1:0] v, input logic [SCALE_W-1:0] s);
		qr_t              res;
		logic [23:0]      prod;
		logic [POS_W-1:0] q3;
		logic [13:0]      rem;
		prod = {12'd0, v} * {12'd0, RECIP_3};
		q3   = {1'b0, prod[23:13]};
		rem  = {2'b00, v} - ({2'b00, q3} + {1'b0, q3, 1'b0});
		unique case (s)
			SCALE_1: begin
				res.q = v;
				res.r = 2'd0;
			end
			SCALE_2: begin
				res.q = {1'b0, v[POS_W-1:1]};
				res.r = {1'b0, v[0]};
			end
			SCALE_3: begin
				res.q = q3;
				res.r = rem[1:0];
			end
			default: begin
				res.q = {2'b00, v[POS_W-1:2]};
				res.r = v[1:0];
			end
		endcase
		return res;
	endfunction

	function automatic logic [PIX_W-1:0] div_area(input logic [SUM_W-1:0] e,
			input logic [SCALE_W-1:0] s);
		logic [24:0]      prod;
		logic [PIX_W-1:0] res;
		prod = {13'd0, e} * {12'd0, RECIP_9};
		unique case (s)
			SCALE_1: res = e[7:0];
			SCALE_2: res = e[9:2];
			SCALE_3: res = prod[23:16];
			default: res = e[11:4];
		endcase
		return res;
	endfunction

endpackage

@@ rtl/bad_col_acc.sv @@
// ----------------------------------------------------------------------------
// Column sum accumulator
// Line store of per-block column sums: read, add the row sum (or just store it
// on a first row), write back, forwarding back-to-back updates of one entry.
// ----------------------------------------------------------------------------
module bad_col_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  bad_pkg::acc_req_t req,
	output bad_pkg::acc_res_t res
);

	logic [3*bad_pkg::SUM_W-1:0] mem [bad_pkg::LINE_DEPTH];

	logic                          wr_s1;
	logic                          outp_s1;
	logic                          fwd_s1;
	logic                          ry0_s1;
	logic [bad_pkg::IDX_W-1:0]     idx_s1;
	bad_pkg::sums_t                rs_s1;
	bad_pkg::sums_t                rd_s1;
	bad_pkg::sums_t                fwd_data_s1;
	logic                          row_end_s1;
	logic                          frame_end_s1;
	logic [bad_pkg::SCALE_W-1:0]   scale_s1;
	logic                          outp_s2;
	bad_pkg::sums_t                sums_s2;
	logic                          row_end_s2;
	logic                          frame_end_s2;
	logic [bad_pkg::SCALE_W-1:0]   scale_s2;
	bad_pkg::sums_t                base;
	bad_pkg::sums_t                wdata;

	always_comb begin
		base = fwd_s1 ? fwd_data_s1 : rd_s1;
		if (ry0_s1) begin
			wdata = rs_s1;
		end else begin
			wdata.b = base.b + rs_s1.b;
			wdata.g = base.g + rs_s1.g;
			wdata.r = base.r + rs_s1.r;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			mem[idx_s1] <= wdata;
		end
		if (req.wr) begin
			rd_s1 <= mem[req.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1   <= 1'b0;
			outp_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
			outp_s2 <= 1'b0;
		end else begin
			wr_s1   <= req.wr;
			outp_s1 <= req.outp;
			fwd_s1  <= req.wr && wr_s1 && (req.idx == idx_s1);
			outp_s2 <= outp_s1 && wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		ry0_s1       <= req.ry0;
		idx_s1       <= req.idx;
		rs_s1        <= req.sums;
		row_end_s1   <= req.row_end;
		frame_end_s1 <= req.frame_end;
		scale_s1     <= req.scale;
		fwd_data_s1  <= wdata;
		sums_s2      <= wdata;
		row_end_s2   <= row_end_s1;
		frame_end_s2 <= frame_end_s1;
		scale_s2     <= scale_s1;
	end

	always_comb begin
		res.outp      = outp_s2;
		res.sums      = sums_s2;
		res.row_end   = row_end_s2;
		res.frame_end = frame_end_s2;
		res.scale     = scale_s2;
	end

	a_out_implies_wr: assert property (@(posedge clk) disable iff (!arst_n)
		req.outp |-> req.wr)
		else $error("block result requested without a line store update");

	a_res_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(req.outp && req.wr) |=> ##1 res.outp)
		else $error("block result lost in accumulator");

endmodule

@@ rtl/box_average_downscaler.sv @@
// ----------------------------------------------------------------------------
// Box average downscaler
// Shrinks a BGR raster by k (1 to 4), giving the truncated mean of each
// k by k block through a column sum line store.
// ----------------------------------------------------------------------------
// Path: a completed block passes the accumulator's s1 and s2 registers and is
// then written into the result queue, whose count register drives out_valid.
// Throughput: one pixel per cycle while in_ready is high, set by the single
// read and write port of the line store, with one level of forwarding for a
// repeated entry. Reset: positions and row sums clear, factor 1, 640 by 480;
// the line store is not cleared; a block's first row ignores the old entry.
// ----------------------------------------------------------------------------
module box_average_downscaler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [bad_pkg::HEIGHT_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bad_pkg::pix_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bad_pkg::pix_out_t            out_data
);

	localparam int unsigned CW = bad_pkg::POS_W + 2;

	logic [bad_pkg::SCALE_W-1:0]  scale_q;
	logic [bad_pkg::WIDTH_W-1:0]  width_q;
	logic [bad_pkg::HEIGHT_W-1:0] height_q;
	logic [bad_pkg::POS_W-1:0]    col_q;
	logic [bad_pkg::POS_W-1:0]    row_q;
	bad_pkg::sums_t               rs_q;

	logic [bad_pkg::WIDTH_W-1:0]  w_eff;
	logic [bad_pkg::HEIGHT_W-1:0] h_eff;
	logic [2:0]                   k;
	logic [bad_pkg::POS_W-1:0]    c;
	logic [bad_pkg::POS_W-1:0]    r;
	bad_pkg::qr_t                 cqr;
	bad_pkg::qr_t                 rqr;
	logic [CW-1:0]                base_c;
	logic [CW-1:0]                base_r;
	logic                         in_x;
	logic                         in_y;
	logic                         last_col;
	logic                         last_row;
	logic                         act;
	logic [CW-1:0]                c_inc;
	logic [CW-1:0]                r_inc;
	logic [bad_pkg::POS_W-1:0]    col_d;
	logic [bad_pkg::POS_W-1:0]    row_d;
	bad_pkg::sums_t               rs_d;
	logic                         accept;

	bad_pkg::acc_req_t            req;
	bad_pkg::acc_res_t            res;
	logic                         pend_s1;

	bad_pkg::pix_out_t            fifo_q [bad_pkg::FIFO_DEPTH];
	logic [bad_pkg::FIFO_PTR_W-1:0] wp_q;
	logic [bad_pkg::FIFO_PTR_W-1:0] rp_q;
	logic [bad_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic [bad_pkg::FIFO_CNT_W:0]   occ;
	logic                           push;
	logic                           pop;
	bad_pkg::pix_out_t              push_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= bad_pkg::SCALE_1;
			width_q  <= bad_pkg::WIDTH_W'(640);
			height_q <= bad_pkg::HEIGHT_W'(480);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bad_pkg::CFG_SCALE:  scale_q  <= cfg_data[bad_pkg::SCALE_W-1:0];
				bad_pkg::CFG_WIDTH:  width_q  <= cfg_data[bad_pkg::WIDTH_W-1:0];
				bad_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// block position and row sums
	always_comb begin
		if (width_q == '0) begin
			w_eff = bad_pkg::WIDTH_W'(1);
		end else if (width_q > bad_pkg::WIDTH_W'(bad_pkg::LINE_DEPTH)) begin
			w_eff = bad_pkg::WIDTH_W'(bad_pkg::LINE_DEPTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = bad_pkg::HEIGHT_W'(1);
		end else if (height_q > bad_pkg::HEIGHT_W'(bad_pkg::MAX_HEIGHT)) begin
			h_eff = bad_pkg::HEIGHT_W'(bad_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		k = {1'b0, scale_q} + 3'd1;
		c = in_data.frame_start ? '0 : col_q;
		r = in_data.frame_start ? '0 : row_q;
		cqr = bad_pkg::div_k(c, scale_q);
		rqr = bad_pkg::div_k(r, scale_q);
		base_c = CW'(c) - CW'(cqr.r);
		base_r = CW'(r) - CW'(rqr.r);
		in_x     = (base_c + CW'(k)) <= CW'(w_eff);
		in_y     = (base_r + CW'(k)) <= CW'(h_eff);
		last_col = (base_c + CW'({k, 1'b0})) > CW'(w_eff);
		last_row = (base_r + CW'({k, 1'b0})) > CW'(h_eff);
		act = in_x && in_y;

		c_inc = CW'(c) + CW'(1);
		r_inc = CW'(r) + CW'(1);
		if (c_inc >= CW'(w_eff)) begin
			col_d = '0;
			row_d = (r_inc >= CW'(h_eff)) ? '0 : r_inc[bad_pkg::POS_W-1:0];
		end else begin
			col_d = c_inc[bad_pkg::POS_W-1:0];
			row_d = r;
		end

		if (cqr.r == 2'd0) begin
			rs_d.b = bad_pkg::SUM_W'(in_data.in_blue);
			rs_d.g = bad_pkg::SUM_W'(in_data.in_green);
			rs_d.r = bad_pkg::SUM_W'(in_data.in_red);
		end else begin
			rs_d.b = rs_q.b + bad_pkg::SUM_W'(in_data.in_blue);
			rs_d.g = rs_q.g + bad_pkg::SUM_W'(in_data.in_green);
			rs_d.r = rs_q.r + bad_pkg::SUM_W'(in_data.in_red);
		end
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rs_q  <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
			if (act) begin
				rs_q <= rs_d;
			end
		end
	end

	always_comb begin
		req.wr        = accept && act && (cqr.r == scale_q);
		req.outp      = req.wr && (rqr.r == scale_q);
		req.ry0       = (rqr.r == 2'd0);
		req.idx       = cqr.q[bad_pkg::IDX_W-1:0];
		req.sums      = rs_d;
		req.row_end   = last_col;
		req.frame_end = last_col && last_row;
		req.scale     = scale_q;
	end

	bad_col_acc u_col_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	// result queue, sized to cover the words in flight
	always_comb begin
		push_data.out_blue  = bad_pkg::div_area(res.sums.b, res.scale);
		push_data.out_green = bad_pkg::div_area(res.sums.g, res.scale);
		push_data.out_red   = bad_pkg::div_area(res.sums.r, res.scale);
		push_data.row_end   = res.row_end;
		push_data.frame_end = res.frame_end;
	end

	assign push      = res.outp;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = fifo_q[rp_q];
	assign occ       = (bad_pkg::FIFO_CNT_W + 1)'(cnt_q)
		+ (bad_pkg::FIFO_CNT_W + 1)'(pend_s1)
		+ (bad_pkg::FIFO_CNT_W + 1)'(res.outp);
	assign in_ready  = occ < (bad_pkg::FIFO_CNT_W + 1)'(bad_pkg::FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			wp_q    <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
		end else begin
			pend_s1 <= req.outp;
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (cnt_q != bad_pkg::FIFO_CNT_W'(bad_pkg::FIFO_DEPTH)))
		else $error("result queue overflow");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (bad_pkg::FIFO_CNT_W + 1)'(bad_pkg::FIFO_DEPTH))
		else $error("more words in flight than queue room");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.frame_end) |-> push_data.row_end)
		else $error("frame end without row end");

	a_pend_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> res.outp)
		else $error("pending block result did not arrive");

endmodule

@@ test/box_average_downscaler_tb.sv @@
// ----------------------------------------------------------------------------
// Box average downscaler testbench
// Streams BGR rasters through the downscaler under a range of factors and
// frame sizes. A model of the line store and block sums inside the bench
// predicts each averaged pixel; every accepted output word is compared field
// by field. Covers register extremes, clamped sizes, mid-frame
// reconfiguration, broken frames and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_average_downscaler_tb;

	localparam int unsigned LIMIT       = 500000;
	localparam int unsigned DRAIN       = 16;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned IDLE_PCT    = 17;
	localparam int unsigned RANDOM_GOAL = 440;
	localparam int unsigned EDGE_RUN    = 24;

	typedef enum int unsigned {FILL_RANDOM, FILL_MAX, FILL_ZERO} fill_t;

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [1:0]                   cfg_index = bad_pkg::CFG_SCALE;
	logic [bad_pkg::HEIGHT_W-1:0] cfg_data  = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	bad_pkg::pix_in_t             in_data   = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	bad_pkg::pix_out_t            out_data;

	bad_pkg::pix_in_t  raster_queue[$];
	bad_pkg::pix_out_t awaited[$];

	// shadow of the block: settings, line store, positions, run sums
	logic [bad_pkg::SCALE_W-1:0]  scale_set  = bad_pkg::SCALE_1;
	logic [bad_pkg::WIDTH_W-1:0]  width_set  = 12'd640;
	logic [bad_pkg::HEIGHT_W-1:0] height_set = 13'd480;
	bad_pkg::sums_t               col_store [bad_pkg::LINE_DEPTH];
	bad_pkg::sums_t               run_sum    = '0;
	logic [bad_pkg::POS_W-1:0]    col_at     = '0;
	logic [bad_pkg::POS_W-1:0]    row_at     = '0;

	bit          calm          = 1'b0;
	bit          hold_off_req  = 1'b0;
	bit          hold_served   = 1'b0;
	int unsigned hold_left     = 0;
	int unsigned error_count   = 0;
	int unsigned items_taken   = 0;
	int unsigned results_seen  = 0;
	int unsigned reg_writes    = 0;
	int unsigned cycle_count   = 0;

	box_average_downscaler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag(input string msg);
		error_count++;
		if (error_count <= 200)
			$display("mismatch %0d: %s", error_count, msg);
	endtask

	task automatic check_field(input string name, input logic [bad_pkg::PIX_W-1:0] got,
			input logic [bad_pkg::PIX_W-1:0] want);
		if (got !== want)
			flag($sformatf("word %0d %s got %0h want %0h", results_seen, name, got, want));
	endtask

	function automatic int unsigned cols_now();
		if (width_set == 0) return 1;
		if (width_set > bad_pkg::LINE_DEPTH) return bad_pkg::LINE_DEPTH;
		return width_set;
	endfunction

	function automatic int unsigned rows_now();
		if (height_set == 0) return 1;
		if (height_set > bad_pkg::MAX_HEIGHT) return bad_pkg::MAX_HEIGHT;
		return height_set;
	endfunction

	function automatic int unsigned factor_now();
		return int'(scale_set) + 1;
	endfunction

	task automatic shrink_pixel(input bad_pkg::pix_in_t px);
		int unsigned       w, h, k, c, row, cx, ry, bc, by, blocks_x, blocks_y, area, idx;
		bad_pkg::pix_out_t res;
		w = cols_now();
		h = rows_now();
		k = factor_now();
		blocks_x = w / k;
		blocks_y = h / k;
		if (px.frame_start) begin
			col_at = '0;
			row_at = '0;
		end
		c   = col_at;
		row = row_at;
		cx  = c % k;
		ry  = row % k;
		bc  = c / k;
		by  = row / k;
		if (bc < blocks_x && by < blocks_y) begin
			if (cx == 0) begin
				run_sum.b = {4'd0, px.in_blue};
				run_sum.g = {4'd0, px.in_green};
				run_sum.r = {4'd0, px.in_red};
			end else begin
				run_sum.b = run_sum.b + px.in_blue;
				run_sum.g = run_sum.g + px.in_green;
				run_sum.r = run_sum.r + px.in_red;
			end
			if (cx == k - 1) begin
				idx = bc % bad_pkg::LINE_DEPTH;
				if (ry == 0) begin
					col_store[idx] = run_sum;
				end else begin
					col_store[idx].b = col_store[idx].b + run_sum.b;
					col_store[idx].g = col_store[idx].g + run_sum.g;
					col_store[idx].r = col_store[idx].r + run_sum.r;
				end
				if (ry == k - 1) begin
					area = k * k;
					res.out_blue  = 8'(col_store[idx].b / area);
					res.out_green = 8'(col_store[idx].g / area);
					res.out_red   = 8'(col_store[idx].r / area);
					res.row_end   = (bc == blocks_x - 1);
					res.frame_end = res.row_end && (by == blocks_y - 1);
					awaited.push_back(res);
				end
			end
		end
		c++;
		if (c >= w) begin
			c = 0;
			row++;
			if (row >= h) row = 0;
		end
		col_at = c[bad_pkg::POS_W-1:0];
		row_at = row[bad_pkg::POS_W-1:0];
	endtask

	// input side: hold the word until taken, idle at random
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (raster_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				in_data  <= raster_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: stall at random, or hold off for a long stretch once asked
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_off_req && !hold_served) begin
				out_ready   <= 1'b0;
				hold_left   <= HOLD_CYCLES;
				hold_served <= 1'b1;
			end else begin
				out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// check results first, then model the word taken at this edge
	always @(posedge clk) begin : watch
		bad_pkg::pix_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited.size() == 0) begin
					flag($sformatf("word %0d arrived with nothing awaited", results_seen));
				end else begin
					want = awaited.pop_front();
					check_field("blue", out_data.out_blue, want.out_blue);
					check_field("green", out_data.out_green, want.out_green);
					check_field("red", out_data.out_red, want.out_red);
					check_field("row_end", {7'd0, out_data.row_end}, {7'd0, want.row_end});
					check_field("frame_end", {7'd0, out_data.frame_end},
						{7'd0, want.frame_end});
				end
			end
			if (in_valid && in_ready) begin
				items_taken++;
				shrink_pixel(in_data);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("timeout after %0d cycles, %0d words awaited", LIMIT, awaited.size());
			$display("FAIL box_average_downscaler");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [bad_pkg::HEIGHT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			bad_pkg::CFG_SCALE:  scale_set  = val[bad_pkg::SCALE_W-1:0];
			bad_pkg::CFG_WIDTH:  width_set  = val[bad_pkg::WIDTH_W-1:0];
			bad_pkg::CFG_HEIGHT: height_set = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_shape(input logic [bad_pkg::SCALE_W-1:0] sc,
			input logic [bad_pkg::HEIGHT_W-1:0] w, input logic [bad_pkg::HEIGHT_W-1:0] h);
		write_reg(bad_pkg::CFG_SCALE, {11'd0, sc});
		write_reg(bad_pkg::CFG_WIDTH, w);
		write_reg(bad_pkg::CFG_HEIGHT, h);
	endtask

	task automatic settle();
		@(negedge clk);
		while (raster_queue.size() != 0 || in_valid || awaited.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	function automatic logic [bad_pkg::PIX_W-1:0] channel_value(input fill_t fill);
		case (fill)
			FILL_MAX:  return 8'hFF;
			FILL_ZERO: return 8'h00;
			default:   return bad_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic fill_t pick_fill();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70) return FILL_RANDOM;
		if (r < 85) return FILL_MAX;
		return FILL_ZERO;
	endfunction

	task automatic push_pixel(input logic [bad_pkg::PIX_W-1:0] b,
			input logic [bad_pkg::PIX_W-1:0] g, input logic [bad_pkg::PIX_W-1:0] r,
			input logic fs);
		bad_pkg::pix_in_t px;
		px.in_blue     = b;
		px.in_green    = g;
		px.in_red      = r;
		px.frame_start = fs;
		raster_queue.push_back(px);
	endtask

	task automatic queue_run(input int unsigned count, input bit mark, input fill_t fill,
			input int unsigned fs_pct);
		int unsigned n;
		@(negedge clk);
		for (n = 0; n < count; n++)
			push_pixel(channel_value(fill), channel_value(fill), channel_value(fill),
				(n == 0) ? mark : ($urandom_range(99) < fs_pct));
	endtask

	initial begin : stimulus
		int unsigned                 random_items, phase, budget, sent, n, w, h, fs_pct;
		logic [bad_pkg::SCALE_W-1:0] sc;
		bit                          first;

		random_items = 0;
		phase        = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: factor 1, 640 by 480
		push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		push_pixel(8'h5A, 8'hA5, 8'h3C, 1'b0);
		settle();
		set_shape(bad_pkg::SCALE_2, 13'd2, 13'd2);
		queue_run(4, 1'b1, FILL_MAX, 0);
		settle();
		set_shape(bad_pkg::SCALE_3, 13'd3, 13'd3);
		queue_run(9, 1'b1, FILL_MAX, 0);
		settle();
		// drop the leftover column and row
		set_shape(bad_pkg::SCALE_2, 13'd3, 13'd3);
		queue_run(9, 1'b1, FILL_RANDOM, 0);
		settle();
		// zero sizes read as one
		set_shape(bad_pkg::SCALE_1, 13'd0, 13'd0);
		queue_run(2, 1'b1, FILL_RANDOM, 0);
		settle();

		// write part of the line store, stop mid-row, then change shape mid-frame
		set_shape(bad_pkg::SCALE_1, 13'd64, 13'd4);
		queue_run(104, 1'b1, FILL_RANDOM, 0);
		settle();
		set_shape(bad_pkg::SCALE_4, 13'd16, 13'd8);
		queue_run(97, 1'b0, FILL_RANDOM, 0);
		settle();

		// long output stall with the input kept busy
		set_shape(bad_pkg::SCALE_1, 13'd16, 13'd8);
		calm         = 1'b1;
		hold_off_req = 1'b1;
		queue_run(128, 1'b1, FILL_RANDOM, 0);
		settle();
		calm = 1'b0;

		// oversized registers clamp to the largest frame
		set_shape(bad_pkg::SCALE_1, 13'h0FFF, 13'd1);
		queue_run(EDGE_RUN, 1'b1, FILL_RANDOM, 0);
		settle();
		set_shape(bad_pkg::SCALE_1, 13'd1, 13'h1FFF);
		queue_run(EDGE_RUN, 1'b1, FILL_RANDOM, 0);
		settle();

		while (random_items < RANDOM_GOAL) begin
			phase++;
			calm = (phase == 6);
			sc   = bad_pkg::SCALE_W'($urandom_range(0, 3));
			if ($urandom_range(9) == 0) begin
				w = $urandom_range(25, 80);
				h = $urandom_range(1, 4);
			end else begin
				w = $urandom_range(1, 20);
				h = $urandom_range(1, 12);
			end
			set_shape(sc, bad_pkg::HEIGHT_W'(w), bad_pkg::HEIGHT_W'(h));
			budget = $urandom_range(16, 48);
			sent   = 0;
			first  = 1'b1;
			while (sent < budget) begin
				n = cols_now() * rows_now();
				if ($urandom_range(99) < 15) n = $urandom_range(1, n);
				fs_pct = ($urandom_range(99) < 20) ? 5 : 0;
				queue_run(n, first || ($urandom_range(1) == 1), pick_fill(), fs_pct);
				sent += n;
				first = 1'b0;
			end
			settle();
			random_items += sent;
		end
		calm = 1'b0;

		if (awaited.size() != 0)
			flag($sformatf("%0d words never arrived", awaited.size()));
		$display("run covered %0d pixels in, %0d averaged words out, %0d register writes",
			items_taken, results_seen, reg_writes);
		$display("factors 1 to 4, clamped sizes, mid-frame change, %0d-cycle output stall",
			HOLD_CYCLES);
		if (error_count == 0) begin
			$display("PASS box_average_downscaler");
		end else begin
			$display("FAIL box_average_downscaler");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bad_pkg.sv
rtl/bad_col_acc.sv
rtl/box_average_downscaler.sv
test/box_average_downscaler_tb.sv
